// File: sv/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

    // Hue scale: 1/64 degree per step
    localparam logic [12:0] HUE_PER_SECTOR = 13'd3840;
    localparam logic [14:0] HUE_FULL       = 15'd23040;

    // floor(n / 15) = (n * RECIP_15) >> 16 for n below 4096
    localparam logic [12:0] RECIP_15 = 13'd4370;

    // Sector codes, one per 60 degrees
    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;

    // Input item
    typedef struct packed {
        logic [14:0] hue;
        logic        hue_undefined;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_item_t;

    // Decode stage output: chroma, offset and hue weight
    typedef struct packed {
        logic        valid;
        logic        grey;
        logic [2:0]  sector;
        logic [11:0] weight;
        logic [7:0]  chroma;
        logic [7:0]  offset;
    } chroma_t;

    // Interpolation stage output: all three channel components
    typedef struct packed {
        logic        valid;
        logic        grey;
        logic [2:0]  sector;
        logic [7:0]  chroma;
        logic [7:0]  offset;
        logic [7:0]  inter;
    } mix_t;

endpackage

// File: sv/hsv_to_rgb_pixel_converter.sv
// HSV to RGB pixel converter top level: five-stage pipeline.
//
// Usage:
//   Drive an HSV item on pixel and raise start for one cycle per item.
//   An item is taken at every rising edge where start is high and busy is
//   low; busy stays low, so a new item may enter in every cycle.
//   Each result appears on result for exactly one cycle with done high,
//   once the item has passed all five register stages; results come
//   out in input order.
//   Throughput is one item per clock; the five register stages are
//   sector decode and v*s, divide by 255, chroma times hue weight,
//   reciprocal multiply for the divide by 3840, channel routing.
//   The receiver cannot stall: it must take each result in its done cycle.
//   Reset (rst_n low) clears all stage valid bits, so no done strobe comes
//   out for items in flight at reset; payload registers are not cleared.
module hsv_to_rgb_pixel_converter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  hsv2rgb_pkg::hsv_item_t pixel,
    output logic                   done,
    output hsv2rgb_pkg::rgb_item_t result
);
    import hsv2rgb_pkg::*;

    chroma_t chroma_bus;
    mix_t    mix_bus;
    logic    accept;

    // Pipeline never holds off the source
    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsv2rgb_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (accept),
        .pixel   (pixel),
        .decoded (chroma_bus)
    );

    hsv2rgb_interp u_interp (
        .clk     (clk),
        .rst_n   (rst_n),
        .decoded (chroma_bus),
        .mixed   (mix_bus)
    );

    hsv2rgb_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .mixed  (mix_bus),
        .done   (done),
        .result (result)
    );

endmodule

// File: sv/hsv2rgb_decode.sv
// Hue sector decode and chroma computation, two pipeline stages.
module hsv2rgb_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    input  hsv2rgb_pkg::hsv_item_t pixel,
    output hsv2rgb_pkg::chroma_t   decoded
);
    import hsv2rgb_pkg::*;

    // Stage 1 registers
    logic        s1_valid_reg;
    logic        s1_grey_reg;
    logic [2:0]  s1_sector_reg;
    logic [11:0] s1_frac_reg;
    logic [15:0] s1_prod_reg;
    logic [7:0]  s1_bright_reg;

    logic        s1_grey_next;
    logic [2:0]  s1_sector_next;
    logic [11:0] s1_frac_next;
    logic [15:0] s1_prod_next;
    logic [14:0] hue_eff;
    logic [14:0] sector_base;
    logic [14:0] frac_full;

    // Stage 2 registers
    logic        s2_valid_reg;
    logic        s2_grey_reg;
    logic [2:0]  s2_sector_reg;
    logic [11:0] s2_weight_reg;
    logic [7:0]  s2_chroma_reg;
    logic [7:0]  s2_offset_reg;

    logic [11:0] s2_weight_next;
    logic [7:0]  s2_chroma_next;
    logic [7:0]  s2_offset_next;
    logic [16:0] div_sum;

    // Fold a full turn to zero, find the sector by compares
    always_comb
    begin
        hue_eff      = (pixel.hue == HUE_FULL) ? 15'd0 : pixel.hue;
        s1_grey_next = pixel.hue_undefined || (pixel.hue > HUE_FULL);
        if (hue_eff >= 15'(5 * HUE_PER_SECTOR))
        begin
            s1_sector_next = SECTOR_5;
            sector_base    = 15'(5 * HUE_PER_SECTOR);
        end
        else if (hue_eff >= 15'(4 * HUE_PER_SECTOR))
        begin
            s1_sector_next = SECTOR_4;
            sector_base    = 15'(4 * HUE_PER_SECTOR);
        end
        else if (hue_eff >= 15'(3 * HUE_PER_SECTOR))
        begin
            s1_sector_next = SECTOR_3;
            sector_base    = 15'(3 * HUE_PER_SECTOR);
        end
        else if (hue_eff >= 15'(2 * HUE_PER_SECTOR))
        begin
            s1_sector_next = SECTOR_2;
            sector_base    = 15'(2 * HUE_PER_SECTOR);
        end
        else if (hue_eff >= 15'(HUE_PER_SECTOR))
        begin
            s1_sector_next = SECTOR_1;
            sector_base    = 15'(HUE_PER_SECTOR);
        end
        else
        begin
            s1_sector_next = SECTOR_0;
            sector_base    = 15'd0;
        end
        frac_full    = hue_eff - sector_base;
        s1_frac_next = frac_full[11:0];
        s1_prod_next = {8'd0, pixel.brightness} * {8'd0, pixel.saturation};
    end

    // Divide by 255 exactly, mirror the weight in odd sectors
    always_comb
    begin
        div_sum        = {1'b0, s1_prod_reg} + {9'd0, s1_prod_reg[15:8]} + 17'd1;
        s2_chroma_next = div_sum[15:8];
        s2_offset_next = s1_bright_reg - s2_chroma_next;
        if (s1_sector_reg[0])
        begin
            s2_weight_next = 12'(HUE_PER_SECTOR) - s1_frac_reg;
        end
        else
        begin
            s2_weight_next = s1_frac_reg;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s1_grey_reg   <= s1_grey_next;
        s1_sector_reg <= s1_sector_next;
        s1_frac_reg   <= s1_frac_next;
        s1_prod_reg   <= s1_prod_next;
        s1_bright_reg <= pixel.brightness;
        s2_grey_reg   <= s1_grey_reg;
        s2_sector_reg <= s1_sector_reg;
        s2_weight_reg <= s2_weight_next;
        s2_chroma_reg <= s2_chroma_next;
        s2_offset_reg <= s2_offset_next;
    end

    assign decoded.valid  = s2_valid_reg;
    assign decoded.grey   = s2_grey_reg;
    assign decoded.sector = s2_sector_reg;
    assign decoded.weight = s2_weight_reg;
    assign decoded.chroma = s2_chroma_reg;
    assign decoded.offset = s2_offset_reg;

endmodule

// File: sv/hsv2rgb_interp.sv
// Intermediate component x = chroma * weight / 3840, two pipeline stages.
module hsv2rgb_interp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hsv2rgb_pkg::chroma_t decoded,
    output hsv2rgb_pkg::mix_t    mixed
);
    import hsv2rgb_pkg::*;

    // Stage 3 registers
    logic        s3_valid_reg;
    logic        s3_grey_reg;
    logic [2:0]  s3_sector_reg;
    logic [7:0]  s3_chroma_reg;
    logic [7:0]  s3_offset_reg;
    logic [19:0] s3_prod_reg;
    logic [19:0] s3_prod_next;

    // Stage 4 registers
    logic        s4_valid_reg;
    logic        s4_grey_reg;
    logic [2:0]  s4_sector_reg;
    logic [7:0]  s4_chroma_reg;
    logic [7:0]  s4_offset_reg;
    logic [7:0]  s4_inter_reg;
    logic [7:0]  s4_inter_next;
    logic [24:0] recip_prod;

    // Scale chroma by the hue weight
    assign s3_prod_next = {12'd0, decoded.chroma} * {8'd0, decoded.weight};

    // Divide by 3840: drop 8 bits, then multiply by the reciprocal of 15
    always_comb
    begin
        recip_prod    = {13'd0, s3_prod_reg[19:8]} * {12'd0, RECIP_15};
        s4_inter_next = recip_prod[23:16];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= decoded.valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s3_grey_reg   <= decoded.grey;
        s3_sector_reg <= decoded.sector;
        s3_chroma_reg <= decoded.chroma;
        s3_offset_reg <= decoded.offset;
        s3_prod_reg   <= s3_prod_next;
        s4_grey_reg   <= s3_grey_reg;
        s4_sector_reg <= s3_sector_reg;
        s4_chroma_reg <= s3_chroma_reg;
        s4_offset_reg <= s3_offset_reg;
        s4_inter_reg  <= s4_inter_next;
    end

    assign mixed.valid  = s4_valid_reg;
    assign mixed.grey   = s4_grey_reg;
    assign mixed.sector = s4_sector_reg;
    assign mixed.chroma = s4_chroma_reg;
    assign mixed.offset = s4_offset_reg;
    assign mixed.inter  = s4_inter_reg;

endmodule

// File: sv/hsv2rgb_mix.sv
// Channel assignment by sector and grey offset, output register stage.
module hsv2rgb_mix (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hsv2rgb_pkg::mix_t      mixed,
    output logic                   done,
    output hsv2rgb_pkg::rgb_item_t result
);
    import hsv2rgb_pkg::*;

    logic      done_reg;
    rgb_item_t result_reg;
    rgb_item_t result_next;
    logic [7:0] r_comp;
    logic [7:0] g_comp;
    logic [7:0] b_comp;

    // Route chroma and the intermediate to channels, then add the offset
    always_comb
    begin
        r_comp = 8'd0;
        g_comp = 8'd0;
        b_comp = 8'd0;
        if (!mixed.grey)
        begin
            case (mixed.sector)
                SECTOR_0:
                begin
                    r_comp = mixed.chroma;
                    g_comp = mixed.inter;
                end
                SECTOR_1:
                begin
                    r_comp = mixed.inter;
                    g_comp = mixed.chroma;
                end
                SECTOR_2:
                begin
                    g_comp = mixed.chroma;
                    b_comp = mixed.inter;
                end
                SECTOR_3:
                begin
                    g_comp = mixed.inter;
                    b_comp = mixed.chroma;
                end
                SECTOR_4:
                begin
                    r_comp = mixed.inter;
                    b_comp = mixed.chroma;
                end
                default:
                begin
                    r_comp = mixed.chroma;
                    b_comp = mixed.inter;
                end
            endcase
        end
        result_next.red   = r_comp + mixed.offset;
        result_next.green = g_comp + mixed.offset;
        result_next.blue  = b_comp + mixed.offset;
    end

    // Hold the strobe for one cycle per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mixed.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // Grey item gives three equal channels
    assert property (@(posedge clk) disable iff (!rst_n)
        mixed.valid && mixed.grey |=>
            (result.red == result.green) && (result.green == result.blue))
        else $error("grey item produced unequal channels");

    // Colored item has one channel at chroma plus offset
    assert property (@(posedge clk) disable iff (!rst_n)
        mixed.valid && !mixed.grey |=>
            (result.red == 8'($past(mixed.chroma) + $past(mixed.offset))) ||
            (result.green == 8'($past(mixed.chroma) + $past(mixed.offset))) ||
            (result.blue == 8'($past(mixed.chroma) + $past(mixed.offset))))
        else $error("no channel carries the chroma");

    // Colored item has one channel at the bare offset
    assert property (@(posedge clk) disable iff (!rst_n)
        mixed.valid && !mixed.grey |=>
            (result.red == $past(mixed.offset)) ||
            (result.green == $past(mixed.offset)) ||
            (result.blue == $past(mixed.offset)))
        else $error("no channel at the grey offset");

    // Intermediate never exceeds chroma on a colored item
    assert property (@(posedge clk) disable iff (!rst_n)
        mixed.valid && !mixed.grey |-> mixed.inter <= mixed.chroma)
        else $error("intermediate above chroma");
`endif

endmodule

// File: tb/hsv_pixel_checker.sv
// Scoreboard for the HSV to RGB converter: predicts each pixel and checks every result.
module hsv_pixel_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  hsv2rgb_pkg::hsv_item_t pixel,
    input  logic                   done,
    input  hsv2rgb_pkg::rgb_item_t result,
    output int                     mismatches,
    output int                     outstanding,
    output int                     checked
);
    import hsv2rgb_pkg::*;

    localparam int unsigned FULL_SCALE = 255;

    rgb_item_t pending_rgb[$];
    rgb_item_t want;
    int        fail_total    = 0;
    int        checked_total = 0;

    // Integer HSV to RGB: chroma, grey offset, sector and in-sector interpolation
    function automatic rgb_item_t convert_pixel(hsv_item_t px);
        int unsigned chroma;
        int unsigned offset;
        int unsigned angle;
        int unsigned pos;
        int unsigned weight;
        int unsigned inter;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        logic [2:0]  sector;
        rgb_item_t   rgb;
        chroma = (int'(px.brightness) * int'(px.saturation)) / FULL_SCALE;
        offset = int'(px.brightness) - chroma;
        angle  = int'(px.hue);
        r = 0;
        g = 0;
        b = 0;
        // a full turn wraps back to red
        if (angle == HUE_FULL)
            angle = 0;
        if (!px.hue_undefined && angle < HUE_FULL)
        begin
            sector = 3'(angle / HUE_PER_SECTOR);
            pos    = angle % HUE_PER_SECTOR;
            // odd sectors ramp down, even sectors ramp up
            weight = sector[0] ? HUE_PER_SECTOR - pos : pos;
            inter  = (chroma * weight) / HUE_PER_SECTOR;
            case (sector)
                SECTOR_0:
                begin
                    r = chroma;
                    g = inter;
                end
                SECTOR_1:
                begin
                    r = inter;
                    g = chroma;
                end
                SECTOR_2:
                begin
                    g = chroma;
                    b = inter;
                end
                SECTOR_3:
                begin
                    g = inter;
                    b = chroma;
                end
                SECTOR_4:
                begin
                    r = inter;
                    b = chroma;
                end
                default:
                begin
                    r = chroma;
                    b = inter;
                end
            endcase
        end
        rgb.red   = 8'(r + offset);
        rgb.green = 8'(g + offset);
        rgb.blue  = 8'(b + offset);
        return rgb;
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what, int got, int want_val);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want_val);
        fail_total++;
    endtask

    // Check results against the oldest prediction, then queue the new item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rgb.size() == 0)
                    report_mismatch("result with no pixel pending", int'(result), 0);
                else
                begin
                    want = pending_rgb.pop_front();
                    if (result.red !== want.red)
                        report_mismatch("red", int'(result.red), int'(want.red));
                    if (result.green !== want.green)
                        report_mismatch("green", int'(result.green), int'(want.green));
                    if (result.blue !== want.blue)
                        report_mismatch("blue", int'(result.blue), int'(want.blue));
                end
                checked_total++;
            end
            if (start && !busy)
                pending_rgb.insert(pending_rgb.size(), convert_pixel(pixel));
        end
        outstanding <= pending_rgb.size();
        mismatches  <= fail_total;
        checked     <= checked_total;
    end

endmodule

// File: tb/tb.sv
// Top of the HSV to RGB converter testbench: clock, reset, pixel stimulus and verdict.
module tb;
    import hsv2rgb_pkg::*;

    localparam int RANDOM_PIXELS = 1700;
    localparam int IDLE_LIMIT    = 500;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    hsv_item_t pixel;
    rgb_item_t result;

    hsv_item_t directed[$];

    int mismatches;
    int outstanding;
    int checked;
    int sent_total     = 0;
    int directed_total = 0;
    int grey_total     = 0;

    hsv_to_rgb_pixel_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    hsv_pixel_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel       (pixel),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // Clock: period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hsv_item_t make_pixel(int h, bit undef, int s, int v);
        hsv_item_t px;
        px.hue           = 15'(h);
        px.hue_undefined = undef;
        px.saturation    = 8'(s);
        px.brightness    = 8'(v);
        return px;
    endfunction

    // Append one directed pixel to the list
    task automatic add_directed(hsv_item_t px);
        directed.insert(directed.size(), px);
    endtask

    // Random pixel: mostly in-range hues, some sector edges, some out of range
    function automatic hsv_item_t random_pixel();
        int        pick;
        hsv_item_t px;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            px.hue = 15'($urandom_range(int'(HUE_FULL), 32767));
        else if (pick < 16)
            px.hue = 15'($urandom_range(0, 5) * int'(HUE_PER_SECTOR)
                         + $urandom_range(0, 2) * (int'(HUE_PER_SECTOR) - 1) / 2);
        else
            px.hue = 15'($urandom_range(0, int'(HUE_FULL) - 1));
        px.hue_undefined = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 9);
        px.saturation = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        px.brightness = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
        return px;
    endfunction

    // Gap before the next item: mostly none, some short, a few long
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one item, hold it until taken, then idle for gap cycles
    task automatic issue_pixel(hsv_item_t px, int gap);
        start <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (busy);
        sent_total++;
        if (px.hue_undefined || px.hue > HUE_FULL)
            grey_total++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Directed corners, then random pixels with bursts of back-to-back items
    initial
    begin : stimulus
        int n;
        int half;
        half  = int'(HUE_PER_SECTOR) / 2;
        rst_n = 1'b0;
        start <= 1'b0;
        pixel <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_directed(make_pixel(0, 0, 255, 255));
        add_directed(make_pixel(int'(HUE_PER_SECTOR) - 1, 0, 255, 255));
        add_directed(make_pixel(int'(HUE_PER_SECTOR), 0, 255, 255));
        add_directed(make_pixel(2 * int'(HUE_PER_SECTOR) - 1, 0, 255, 255));
        add_directed(make_pixel(2 * int'(HUE_PER_SECTOR), 0, 255, 255));
        add_directed(make_pixel(3 * int'(HUE_PER_SECTOR), 0, 200, 180));
        add_directed(make_pixel(4 * int'(HUE_PER_SECTOR), 0, 255, 255));
        add_directed(make_pixel(5 * int'(HUE_PER_SECTOR), 0, 170, 240));
        add_directed(make_pixel(int'(HUE_FULL) - 1, 0, 255, 255));
        for (int sec = 0; sec < 6; sec++)
            add_directed(make_pixel(sec * int'(HUE_PER_SECTOR) + half, 0, 255, 255));
        // full turn wraps to red
        add_directed(make_pixel(int'(HUE_FULL), 0, 255, 255));
        // hue past a full turn gives grey
        add_directed(make_pixel(int'(HUE_FULL) + 1, 0, 255, 200));
        add_directed(make_pixel(32767, 0, 128, 255));
        // undefined hue gives grey
        add_directed(make_pixel(1000, 1, 255, 255));
        add_directed(make_pixel(0, 1, 0, 0));
        add_directed(make_pixel(5000, 0, 0, 255));
        add_directed(make_pixel(9000, 0, 255, 0));
        add_directed(make_pixel(12345, 0, 128, 200));

        foreach (directed[i])
            issue_pixel(directed[i], $urandom_range(0, 2));
        directed_total = directed.size();

        for (n = 0; n < RANDOM_PIXELS; n++)
            issue_pixel(random_pixel(), ((n % 256) < 64) ? 0 : pick_gap());
        start <= 1'b0;

        // Drain the pipeline, then wait on for any stray results
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Converted %0d pixels (%0d directed, %0d expected grey), %0d results checked",
                 sent_total, directed_total, grey_total, checked);
        if (mismatches == 0)
            $display("hsv_to_rgb_pixel_converter regression: pass");
        else
            $display("hsv_to_rgb_pixel_converter regression: fail");
        $finish;
    end

    // Watchdog: end the run if nothing moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no activity for %0d cycles", IDLE_LIMIT);
        $display("hsv_to_rgb_pixel_converter regression: fail");
        $finish;
    end

endmodule

// File: sim.f
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_decode.sv
sv/hsv2rgb_interp.sv
sv/hsv2rgb_mix.sv
sv/hsv_to_rgb_pixel_converter.sv
tb/hsv_pixel_checker.sv
tb/tb.sv
